[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/opsa_pkg.sv]
// ----------------------------------------------------------------------------
// opsa_pkg
// Widths, opcodes, stream field offsets and lane result type for the
// outer product scatter-add unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package opsa_pkg;

    // Operand and accumulator widths
    localparam int IN_W     = 16;
    localparam int PROD_W   = 2 * IN_W;
    localparam int ACC_W    = 48;
    localparam int IN_ELEMS = 4;
    localparam int ROW_W    = 8;
    localparam int POS_W    = 2;
    localparam int OP_W     = 2;

    // Opcodes carried in the input tuser
    localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Input tdata layout, lowest bit first
    localparam int TD_ROW_LSB = 0;
    localparam int TD_A_LSB   = TD_ROW_LSB + ROW_W;
    localparam int TD_B_LSB   = TD_A_LSB + IN_ELEMS * IN_W;
    localparam int TD_PA_LSB  = TD_B_LSB + IN_ELEMS * IN_W;
    localparam int TD_PB_LSB  = TD_PA_LSB + POS_W;
    localparam int TD_USED_W  = TD_PB_LSB + POS_W;
    localparam int S_TDATA_W  = ((TD_USED_W + 7) / 8) * 8;

    // Saturation bounds
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // One lane's updated element and saturation mark
    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             sat;
    } t_lane_res;

endpackage

[hw/rtl/opsa_ram.sv]
// ----------------------------------------------------------------------------
// opsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opsa_ram #(
    parameter int WIDTH = 768,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/opsa_lane.sv]
// ----------------------------------------------------------------------------
// opsa_lane
// One multiply-accumulate lane: registers a*b on the input beat, then adds
// the product to one stored element with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opsa_lane (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic signed [opsa_pkg::IN_W-1:0] i_a,
    input  logic signed [opsa_pkg::IN_W-1:0] i_b,
    input  logic [opsa_pkg::ACC_W-1:0]    i_acc,
    output opsa_pkg::t_lane_res           o_res
);

    import opsa_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W:0]           w_sum;

    // Capture the product on the input beat
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= i_a * i_b;
        end
    end

    // Sign-extended add, one guard bit
    assign w_sum = {i_acc[ACC_W-1], i_acc}
                 + {{(ACC_W+1-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // Clamp when the guard bit disagrees with the sign
    always_comb begin
        o_res.sat = (w_sum[ACC_W] != w_sum[ACC_W-1]);
        if (o_res.sat) begin
            o_res.sum = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            o_res.sum = w_sum[ACC_W-1:0];
        end
    end

endmodule

[hw/rtl/opsa_merge.sv]
// ----------------------------------------------------------------------------
// opsa_merge
// Combines the lane results into one row word and one saturation flag, and
// picks the addressed element of a stored row for reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opsa_merge #(
    parameter int VEC_A_LEN = 4,
    parameter int VEC_B_LEN = 4,
    parameter int LANES     = VEC_A_LEN * VEC_B_LEN
) (
    input  logic [LANES*opsa_pkg::ACC_W-1:0] i_row,
    input  opsa_pkg::t_lane_res              i_lanes [LANES],
    input  logic [opsa_pkg::POS_W-1:0]       i_pos_a,
    input  logic [opsa_pkg::POS_W-1:0]       i_pos_b,
    output logic [LANES*opsa_pkg::ACC_W-1:0] o_wr_row,
    output logic                             o_any_sat,
    output logic [opsa_pkg::ACC_W-1:0]       o_elem
);

    import opsa_pkg::*;

    localparam int LANE_IW = (LANES > 1) ? $clog2(LANES) : 1;

    logic               w_pos_ok;
    logic [LANE_IW-1:0] w_idx;

    // Pack lane sums into the write-back word and OR the saturation marks
    always_comb begin
        o_any_sat = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            o_wr_row[k*ACC_W +: ACC_W] = i_lanes[k].sum;
            o_any_sat = o_any_sat | i_lanes[k].sat;
        end
    end

    // Element select for reads; out-of-range positions read as zero
    assign w_pos_ok = (32'(i_pos_a) < VEC_A_LEN) && (32'(i_pos_b) < VEC_B_LEN);
    assign w_idx    = LANE_IW'(32'(i_pos_a) * VEC_B_LEN + 32'(i_pos_b));
    assign o_elem   = w_pos_ok ? i_row[w_idx*ACC_W +: ACC_W] : '0;

endmodule

[hw/rtl/outer_product_scatter_add_unit.sv]
// ----------------------------------------------------------------------------
// outer_product_scatter_add_unit
// Row store of VEC_A_LEN x VEC_B_LEN saturating 48-bit accumulators. A beat
// adds the outer product a*b^T into one row, reads one element, or clears
// the whole store.
//
//  Channel  Dir  tdata (low bit up)                           tuser
//  s_axis   in   row_index, a_elem_0..3, b_elem_0..3,         opcode
//                read_a_pos, read_b_pos, zero pad to 144
//  m_axis   out  read_value                                   overflow_seen
//
//  The input beat issues the row read and the lane products; in S_EXEC the
//  updated row is written back or the result is loaded.
//  A read holds in S_EXEC while the output register is still full.
//  Reset and a clear beat start a clearing pass over all OUT_ROWS rows, one
//  row per cycle; s_axis_tready stays low during it.
//  Every store write lands before the next beat is taken, so a row written
//  by one item is read back correctly by the next without forwarding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module outer_product_scatter_add_unit #(
    parameter int OUT_ROWS  = 256,
    parameter int VEC_A_LEN = 4,
    parameter int VEC_B_LEN = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // row_index, a_elem_0..3, b_elem_0..3, read_a_pos, read_b_pos
    input  logic [opsa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // opcode
    input  logic [opsa_pkg::OP_W-1:0]      s_axis_tuser,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // read_value
    output logic [opsa_pkg::ACC_W-1:0]     m_axis_tdata,
    // overflow_seen
    output logic [0:0]                     m_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);

    import opsa_pkg::*;

    localparam int LANES  = VEC_A_LEN * VEC_B_LEN;
    localparam int ROW_AW = (OUT_ROWS > 1) ? $clog2(OUT_ROWS) : 1;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(OUT_ROWS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    // Beat fields
    logic                   w_accept;
    logic [ROW_W-1:0]       w_row;
    logic signed [IN_W-1:0] w_a [IN_ELEMS];
    logic signed [IN_W-1:0] w_b [IN_ELEMS];

    // Control state
    logic [1:0]        r_state, n_state;
    logic [ROW_AW-1:0] r_clr_cnt, n_clr_cnt;
    logic              r_ovf;
    logic              r_out_valid;

    // Item held for the S_EXEC state, and the output register
    logic [OP_W-1:0]   r_op;
    logic [ROW_AW-1:0] r_row;
    logic              r_row_ok;
    logic [POS_W-1:0]  r_pa;
    logic [POS_W-1:0]  r_pb;
    logic [ACC_W-1:0]  r_out_value;
    logic              r_out_ovf;

    // Store ports and lane results
    logic                    w_ram_we;
    logic [ROW_AW-1:0]       w_ram_waddr;
    logic [LANES*ACC_W-1:0]  w_ram_wdata;
    logic [LANES*ACC_W-1:0]  w_ram_rdata;
    t_lane_res               w_lanes [LANES];
    logic [LANES*ACC_W-1:0]  w_wr_row;
    logic                    w_any_sat;
    logic [ACC_W-1:0]        w_elem;
    logic                    w_do_accum;
    logic                    w_do_read;
    logic                    w_out_free;

    // Unpack the input beat
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_row    = s_axis_tdata[TD_ROW_LSB +: ROW_W];
    for (genvar ge = 0; ge < IN_ELEMS; ge++) begin : g_unpack
        assign w_a[ge] = s_axis_tdata[TD_A_LSB + ge*IN_W +: IN_W];
        assign w_b[ge] = s_axis_tdata[TD_B_LSB + ge*IN_W +: IN_W];
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // Row store
    opsa_ram #(
        .WIDTH (LANES * ACC_W),
        .DEPTH (OUT_ROWS),
        .AW    (ROW_AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (ROW_AW'(w_row)),
        .o_rdata (w_ram_rdata)
    );

    // One lane per matrix element; vector elements past the fourth are zero
    for (genvar gi = 0; gi < VEC_A_LEN; gi++) begin : g_row
        for (genvar gj = 0; gj < VEC_B_LEN; gj++) begin : g_col
            localparam int K = gi * VEC_B_LEN + gj;
            logic signed [IN_W-1:0] w_la;
            logic signed [IN_W-1:0] w_lb;
            if (gi < IN_ELEMS) begin : g_a
                assign w_la = w_a[gi];
            end else begin : g_az
                assign w_la = '0;
            end
            if (gj < IN_ELEMS) begin : g_b
                assign w_lb = w_b[gj];
            end else begin : g_bz
                assign w_lb = '0;
            end
            opsa_lane u_lane (
                .i_clk  (i_clk),
                .i_load (w_accept),
                .i_a    (w_la),
                .i_b    (w_lb),
                .i_acc  (w_ram_rdata[K*ACC_W +: ACC_W]),
                .o_res  (w_lanes[K])
            );
        end
    end

    // Merge lane results and pick the read element
    opsa_merge #(
        .VEC_A_LEN (VEC_A_LEN),
        .VEC_B_LEN (VEC_B_LEN),
        .LANES     (LANES)
    ) u_merge (
        .i_row     (w_ram_rdata),
        .i_lanes   (w_lanes),
        .i_pos_a   (r_pa),
        .i_pos_b   (r_pb),
        .o_wr_row  (w_wr_row),
        .o_any_sat (w_any_sat),
        .o_elem    (w_elem)
    );

    // S_EXEC actions
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_do_accum = (r_state == S_EXEC) && (r_op == OP_ACCUM) && r_row_ok;
    assign w_do_read  = (r_state == S_EXEC) && (r_op == OP_READ) && w_out_free;

    // Store write: clearing pass or accumulate write-back
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_clr_cnt;
            w_ram_wdata = '0;
        end else begin
            w_ram_we    = w_do_accum;
            w_ram_waddr = r_row;
            w_ram_wdata = w_wr_row;
        end
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_clr_cnt = '0;
                    n_state   = (s_axis_tuser == OP_CLEAR) ? S_CLEAR : S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op != OP_READ || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + ROW_AW'(1);
                if (r_clr_cnt == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            if (w_accept && s_axis_tuser == OP_CLEAR) begin
                r_ovf <= 1'b0;
            end else if (w_do_accum && w_any_sat) begin
                r_ovf <= 1'b1;
            end
            if (w_do_read) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the item fields for the S_EXEC state
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= s_axis_tuser;
            r_row    <= ROW_AW'(w_row);
            r_row_ok <= (32'(w_row) < OUT_ROWS);
            r_pa     <= s_axis_tdata[TD_PA_LSB +: POS_W];
            r_pb     <= s_axis_tdata[TD_PB_LSB +: POS_W];
        end
    end

    // Output register; rows out of range read as zero
    always_ff @(posedge i_clk) begin
        if (w_do_read) begin
            r_out_value <= r_row_ok ? w_elem : '0;
            r_out_ovf   <= r_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_ovf;

    // Checks
    `ASSERT_NEXT(a_beat_leaves_idle, i_clk, i_rst_n, w_accept, r_state != S_IDLE, "beat accepted but sequencer stayed idle")
    `ASSERT_NEXT(a_ovf_from_accum, i_clk, i_rst_n, !r_ovf, !r_ovf || $past(w_do_accum && w_any_sat), "overflow flag set without a saturating accumulate")
    `ASSERT_IMPLIES(a_exec_write_accum, i_clk, i_rst_n, w_ram_we && r_state != S_CLEAR, r_op == OP_ACCUM && r_row_ok && r_state == S_EXEC, "store written outside an in-range accumulate")
    `ASSERT_IMPLIES(a_clear_flag_low, i_clk, i_rst_n, r_state == S_CLEAR, !r_ovf, "overflow flag set during clearing pass")

endmodule
